// ===== src/pstbq_pkg.sv =====
// Shared constants, codes and refill arithmetic for the per-source token bucket queue.
package pstbq_pkg;

	// Geometry
	localparam int SOURCES         = 8;
	localparam int FIFO_DEPTH      = 8;
	localparam int WORD_BITS       = 64;
	localparam int TOKEN_FRAC_BITS = 12;

	// Field widths fixed by the interface
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 3;
	localparam int TIME_W     = 48;
	localparam int STATUS_W   = 3;
	localparam int LEVEL_W    = 4;
	localparam int BURST_W    = 4;
	localparam int RATE_W     = 10;
	localparam int LIMIT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Derived widths
	localparam int SIDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W  = $clog2(SOURCES * FIFO_DEPTH);
	localparam int TOKEN_W = BURST_W + TOKEN_FRAC_BITS;

	// Refill arithmetic: add = floor(rate * elapsed * 4096 / 1000)
	//                       = 4p + floor(12p / 125) with p = rate * elapsed.
	// Any p of 16000 or more adds at least 65536, above every cap, so p saturates there.
	localparam int ELAPSED_W   = 16;
	localparam int PROD_W      = RATE_W + ELAPSED_W;
	localparam int P_SAT       = 16000;
	localparam int P_W         = 14;
	localparam int REFILL_W    = 17;
	localparam int SUM_W       = 18;
	localparam int TWELVE_P_W  = 18;
	localparam int RECIP_125   = 134218;
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_PW    = TWELVE_P_W + RECIP_W;

	localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(1) << TOKEN_FRAC_BITS;

	// Register reset values
	localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(4);
	localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(4);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE    = 2'd0,
		OP_SERVICE    = 2'd1,
		OP_CLEAR_SLOT = 2'd2,
		OP_CLEAR_ALL  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_QUEUED     = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_BAD_SLOT   = 3'd2,
		ST_DISPATCHED = 3'd3,
		ST_EMPTY      = 3'd4,
		ST_NO_TOKEN   = 3'd5,
		ST_WAITING    = 3'd6,
		ST_CLEARED    = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BURST = 2'd0,
		CFG_RATE  = 2'd1,
		CFG_LIMIT = 2'd2
	} cfg_idx_t;

	// Tokens added for a saturated product p, in fixed point
	function automatic logic [REFILL_W-1:0] refill_amount(input logic [P_W-1:0] p);
		logic [TWELVE_P_W-1:0] twelve_p;
		logic [RECIP_PW-1:0]   scaled;
		twelve_p = (TWELVE_P_W'(p) << 3) + (TWELVE_P_W'(p) << 2);
		scaled   = RECIP_PW'(twelve_p) * RECIP_PW'(RECIP_125);
		return (REFILL_W'(p) << 2) + REFILL_W'(scaled >> RECIP_SHIFT);
	endfunction

endpackage

// ===== src/pstbq_if.sv =====
// Request and response channel interfaces of the token bucket queue.
interface pstbq_req_if import pstbq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [SLOT_W-1:0]    slot;
	logic [WORD_BITS-1:0] request_word;
	logic [TIME_W-1:0]    now_ms;
	logic                 sender_ready;

	modport source (output valid, operation, slot, request_word, now_ms, sender_ready,
		input ready);
	modport sink (input valid, operation, slot, request_word, now_ms, sender_ready,
		output ready);
endinterface

interface pstbq_rsp_if import pstbq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [WORD_BITS-1:0] dispatched_word;
	logic [LEVEL_W-1:0]   queue_level;

	modport source (output valid, status, dispatched_word, queue_level, input ready);
	modport sink (input valid, status, dispatched_word, queue_level, output ready);
endinterface

// ===== src/pstbq_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
module pstbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write the array, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/per_source_token_bucket_queue.sv =====
// Top level: per-source request FIFOs with token bucket rate limiting.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    operation, slot, request_word, now_ms, sender_ready
//   rsp      out        valid/ready    status, dispatched_word, queue_level
//   cfg      in         cfg_we         cfg_index, cfg_data
//
// One beat enters per cycle while the pipeline does not stall; each request gives one response beat.
// Stage s1 reads the slot state and forms rate * elapsed, s2 finishes the refill,
// updates the slot and issues the FIFO RAM access, s3 holds the response.
// A request that reads the same slot as the one in s2 (or follows a clear all) waits
// until s2 retires, so back-to-back traffic on one slot leaves a bubble between beats.
// Reset fills every bucket and empties every FIFO at once; RAM contents are not cleared.
// A stalled rsp holds s3 and backs up into s2, s1 and then req.ready.
module per_source_token_bucket_queue import pstbq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pstbq_req_if.sink             req,
	pstbq_rsp_if.source           rsp
);

	// Configuration registers
	logic [BURST_W-1:0] burst_q;
	logic [RATE_W-1:0]  rate_q;
	logic [LIMIT_W-1:0] limit_q;

	// Per-slot state
	logic [CNT_W-1:0]   count_q [SOURCES];
	logic [PTR_W-1:0]   head_q  [SOURCES];
	logic [TOKEN_W-1:0] level_q [SOURCES];
	logic [TIME_W-1:0]  last_q  [SOURCES];

	// Stage 1
	logic                 valid_s1;
	op_t                  op_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic [TIME_W-1:0]    now_s1;
	logic                 ready_s1;

	// Stage 2
	logic                 valid_s2;
	op_t                  op_s2;
	logic [SLOT_W-1:0]    slot_s2;
	logic [WORD_BITS-1:0] word_s2;
	logic [TIME_W-1:0]    now_s2;
	logic                 ready_s2;
	logic [CNT_W-1:0]     count_s2;
	logic [PTR_W-1:0]     head_s2;
	logic [TOKEN_W-1:0]   level_s2;
	logic                 refill_s2;
	logic [P_W-1:0]       p_s2;

	// Stage 3 (response register)
	logic                 valid_s3;
	status_t              status_s3;
	logic [LEVEL_W-1:0]   qlevel_s3;
	logic                 disp_s3;

	// Handshake
	logic req_fire;
	logic adv_s1;
	logic fire_s2;
	logic conflict;
	logic s1_reads;

	// Stage 1 datapath
	logic [SIDX_W-1:0]    idx_s1;
	logic [TIME_W-1:0]    last_rd;
	logic [TIME_W-1:0]    diff;
	logic [ELAPSED_W-1:0] elapsed;
	logic [PROD_W-1:0]    prod;
	logic                 refill_s1;
	logic [P_W-1:0]       p_s1;

	// Stage 2 datapath
	logic [SIDX_W-1:0]  idx_s2;
	logic               slot_range_ok;
	logic [CNT_W-1:0]   limit_eff;
	logic [TOKEN_W-1:0] cap;
	logic [SUM_W-1:0]   sum;
	logic [TOKEN_W-1:0] lvl_ref;
	logic [PTR_W:0]     tail_sum;
	logic [PTR_W-1:0]   tail;
	logic [PTR_W-1:0]   head_next;
	status_t            status_nx;
	logic [LEVEL_W-1:0] qlevel_nx;
	logic               disp_nx;
	logic               upd;
	logic               clr_all;
	logic [CNT_W-1:0]   new_count;
	logic [PTR_W-1:0]   new_head;
	logic [TOKEN_W-1:0] new_level;
	logic [TIME_W-1:0]  new_last;

	// RAM
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= BURST_RESET;
			rate_q  <= RATE_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BURST: burst_q <= cfg_data[BURST_W-1:0];
				CFG_RATE:  rate_q  <= cfg_data[RATE_W-1:0];
				CFG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and stall control
	assign req_fire  = req.valid && req.ready;
	assign s1_reads  = (op_s1 == OP_ENQUEUE) || (op_s1 == OP_SERVICE);
	assign conflict  = valid_s2 && s1_reads && ((op_s2 == OP_CLEAR_ALL) || (slot_s2 == slot_s1));
	assign fire_s2   = valid_s2 && (!valid_s3 || rsp.ready);
	assign adv_s1    = valid_s1 && (!valid_s2 || fire_s2) && !conflict;
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (fire_s2) begin
				valid_s2 <= 1'b0;
			end
			if (fire_s2) begin
				valid_s3 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1    <= op_t'(req.operation);
			slot_s1  <= req.slot;
			word_s1  <= req.request_word;
			now_s1   <= req.now_ms;
			ready_s1 <= req.sender_ready;
		end
	end

	// Stage 1: read slot state, elapsed time and rate product
	assign idx_s1    = slot_s1[SIDX_W-1:0];
	assign last_rd   = last_q[idx_s1];
	assign refill_s1 = (last_rd != '0) && (now_s1 > last_rd);
	assign diff      = now_s1 - last_rd;
	assign elapsed   = (diff[TIME_W-1:ELAPSED_W] != '0) ? '1 : diff[ELAPSED_W-1:0];
	assign prod      = PROD_W'(rate_q) * PROD_W'(elapsed);

	always_comb begin
		if (!refill_s1) begin
			p_s1 = '0;
		end else if (prod >= PROD_W'(P_SAT)) begin
			p_s1 = P_W'(P_SAT);
		end else begin
			p_s1 = prod[P_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s2     <= op_s1;
			slot_s2   <= slot_s1;
			word_s2   <= word_s1;
			now_s2    <= now_s1;
			ready_s2  <= ready_s1;
			count_s2  <= count_q[idx_s1];
			head_s2   <= head_q[idx_s1];
			level_s2  <= level_q[idx_s1];
			refill_s2 <= refill_s1;
			p_s2      <= p_s1;
		end
	end

	// Stage 2: finish refill, cap and token check
	assign idx_s2        = slot_s2[SIDX_W-1:0];
	assign slot_range_ok = {1'b0, slot_s2} < (SLOT_W + 1)'(SOURCES);
	assign limit_eff     = (CNT_W'(limit_q) > CNT_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH)
		: CNT_W'(limit_q);
	assign cap           = TOKEN_W'(burst_q) << TOKEN_FRAC_BITS;
	assign sum           = SUM_W'(level_s2) + SUM_W'(refill_amount(p_s2));

	always_comb begin
		if (!refill_s2) begin
			lvl_ref = level_s2;
		end else if (sum > SUM_W'(cap)) begin
			lvl_ref = cap;
		end else begin
			lvl_ref = sum[TOKEN_W-1:0];
		end
	end

	// Ring pointers: tail for enqueue, next head for pop
	assign tail_sum  = (PTR_W + 1)'(head_s2) + (PTR_W + 1)'(count_s2);
	assign tail      = (tail_sum >= (PTR_W + 1)'(FIFO_DEPTH))
		? PTR_W'(tail_sum - (PTR_W + 1)'(FIFO_DEPTH)) : tail_sum[PTR_W-1:0];
	assign head_next = ((PTR_W + 1)'(head_s2) == (PTR_W + 1)'(FIFO_DEPTH - 1))
		? '0 : head_s2 + PTR_W'(1);

	// Stage 2: decide the outcome and the slot update
	always_comb begin
		status_nx = ST_BAD_SLOT;
		qlevel_nx = '0;
		disp_nx   = 1'b0;
		upd       = 1'b0;
		clr_all   = 1'b0;
		ram_we    = 1'b0;
		new_count = count_s2;
		new_head  = head_s2;
		new_level = level_s2;
		new_last  = now_s2;
		unique case (op_s2)
			OP_CLEAR_ALL: begin
				status_nx = ST_CLEARED;
				clr_all   = 1'b1;
			end
			OP_CLEAR_SLOT: begin
				if (slot_range_ok) begin
					status_nx = ST_CLEARED;
					upd       = 1'b1;
					new_count = '0;
					new_head  = '0;
					new_level = cap;
					new_last  = '0;
				end
			end
			OP_ENQUEUE: begin
				if (slot_range_ok && (slot_s2 != '0)) begin
					if (count_s2 >= limit_eff) begin
						status_nx = ST_DROPPED;
						qlevel_nx = LEVEL_W'(count_s2);
					end else begin
						status_nx = ST_QUEUED;
						ram_we    = 1'b1;
						upd       = 1'b1;
						new_count = count_s2 + CNT_W'(1);
						new_last  = last_q[idx_s2];
						qlevel_nx = LEVEL_W'(count_s2 + CNT_W'(1));
					end
				end
			end
			OP_SERVICE: begin
				if (slot_range_ok && (slot_s2 != '0)) begin
					if (count_s2 == '0) begin
						status_nx = ST_EMPTY;
					end else begin
						upd       = 1'b1;
						new_level = lvl_ref;
						qlevel_nx = LEVEL_W'(count_s2);
						if (lvl_ref < ONE_TOKEN) begin
							status_nx = ST_NO_TOKEN;
						end else if (ready_s2) begin
							status_nx = ST_DISPATCHED;
							disp_nx   = 1'b1;
							new_level = lvl_ref - ONE_TOKEN;
							new_head  = head_next;
							new_count = count_s2 - CNT_W'(1);
							qlevel_nx = LEVEL_W'(count_s2 - CNT_W'(1));
						end else begin
							status_nx = ST_WAITING;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Slot state: clear all, or write back the addressed slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCES; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				level_q[i] <= TOKEN_W'(BURST_RESET) << TOKEN_FRAC_BITS;
				last_q[i]  <= '0;
			end
		end else if (fire_s2) begin
			if (clr_all) begin
				for (int i = 0; i < SOURCES; i++) begin
					count_q[i] <= '0;
					head_q[i]  <= '0;
					level_q[i] <= cap;
					last_q[i]  <= '0;
				end
			end else if (upd) begin
				count_q[idx_s2] <= new_count;
				head_q[idx_s2]  <= new_head;
				level_q[idx_s2] <= new_level;
				last_q[idx_s2]  <= new_last;
			end
		end
	end

	// FIFO store: append at tail, read head on pop
	assign ram_waddr = ADDR_W'(ADDR_W'(idx_s2) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(tail);
	assign ram_raddr = ADDR_W'(ADDR_W'(idx_s2) * ADDR_W'(FIFO_DEPTH)) + ADDR_W'(head_s2);
	assign ram_re    = fire_s2 && disp_nx;

	pstbq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (SOURCES * FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (fire_s2 && ram_we),
		.waddr (ram_waddr),
		.wdata (word_s2),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Response register
	always_ff @(posedge clk) begin
		if (fire_s2) begin
			status_s3 <= status_nx;
			qlevel_s3 <= qlevel_nx;
			disp_s3   <= disp_nx;
		end
	end

	assign rsp.valid           = valid_s3;
	assign rsp.status          = status_s3;
	assign rsp.queue_level     = qlevel_s3;
	assign rsp.dispatched_word = disp_s3 ? ram_rdata : '0;

`ifndef SYNTHESIS
	// The s2 snapshot of a slot must match the live state until s2 retires
	a_snapshot_coherent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ((op_s2 == OP_ENQUEUE) || (op_s2 == OP_SERVICE)))
		|-> (count_s2 == count_q[idx_s2]) && (head_s2 == head_q[idx_s2])
			&& (level_s2 == level_q[idx_s2]))
		else $error("slot snapshot in s2 is stale");

	// A slot never holds more entries than its FIFO
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (count_s2 <= CNT_W'(FIFO_DEPTH)))
		else $error("FIFO count above depth");

	// Popped word holds while the response is stalled
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !rsp.ready && disp_s3) |=> $stable(ram_rdata))
		else $error("dispatched word changed under stall");

	// A dispatched response leaves room in its FIFO
	a_disp_level: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (status_s3 == ST_DISPATCHED)) |-> (qlevel_s3 < LEVEL_W'(FIFO_DEPTH)))
		else $error("dispatched response reports a full FIFO");
`endif

endmodule

// ===== sim/pstbq_checker.sv =====
// Response checker for the per-source token bucket queue: predicts every response beat.
`timescale 1ns / 1ps
module pstbq_checker import pstbq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pstbq_req_if                  req_mon,
	pstbq_rsp_if                  rsp_mon,
	output int                    fail_count,
	output int                    outstanding
);

	localparam longint unsigned MAX_GAP_MS = 65535;
	localparam longint unsigned MS_PER_S   = 1000;

	typedef struct packed {
		status_t              status;
		logic [WORD_BITS-1:0] word;
		logic [LEVEL_W-1:0]   level;
	} rsp_beat_t;

	// Shadow copy of the register file
	logic [BURST_W-1:0] burst_q;
	logic [RATE_W-1:0]  rate_q;
	logic [LIMIT_W-1:0] limit_q;

	// Shadow copy of the per-slot FIFOs and buckets
	logic [WORD_BITS-1:0] word_ram   [SOURCES*FIFO_DEPTH];
	int                   rd_ptr     [SOURCES];
	int                   depth_used [SOURCES];
	logic [TOKEN_W-1:0]   bucket     [SOURCES];
	logic [TIME_W-1:0]    last_ms    [SOURCES];

	rsp_beat_t due_rsp[$];

	// Empty the FIFO and fill the bucket, marking the slot as never used
	task automatic restore_slot(input int s);
		rd_ptr[s]     = 0;
		depth_used[s] = 0;
		bucket[s]     = TOKEN_W'(burst_q) << TOKEN_FRAC_BITS;
		last_ms[s]    = '0;
	endtask

	// Add rate * elapsed / 1000 tokens, capped at the burst size
	task automatic top_up(input int s, input logic [TIME_W-1:0] now);
		longint unsigned gap;
		longint unsigned add;
		longint unsigned lvl;
		longint unsigned cap;
		cap = longint'(burst_q) << TOKEN_FRAC_BITS;
		if (last_ms[s] != '0 && now > last_ms[s]) begin
			gap = longint'(now - last_ms[s]);
			if (gap > MAX_GAP_MS)
				gap = MAX_GAP_MS;
			add = ((longint'(rate_q) * gap) << TOKEN_FRAC_BITS) / MS_PER_S;
			lvl = longint'(bucket[s]) + add;
			if (lvl > cap)
				lvl = cap;
			bucket[s] = TOKEN_W'(lvl);
		end
		last_ms[s] = now;
	endtask

	// Work out the response to one request beat and advance the shadow state
	task automatic predict_rsp(input op_t op, input logic [SLOT_W-1:0] slot,
			input logic [WORD_BITS-1:0] word, input logic [TIME_W-1:0] now,
			input logic go, output rsp_beat_t r);
		int s;
		int lim;
		int pos;
		s       = int'(slot);
		r.word  = '0;
		r.level = '0;
		if (op == OP_CLEAR_ALL) begin
			for (int i = 0; i < SOURCES; i++)
				restore_slot(i);
			r.status = ST_CLEARED;
		end else if (s >= SOURCES || (op != OP_CLEAR_SLOT && s == 0)) begin
			r.status = ST_BAD_SLOT;
		end else if (op == OP_CLEAR_SLOT) begin
			restore_slot(s);
			r.status = ST_CLEARED;
		end else if (op == OP_ENQUEUE) begin
			lim = (int'(limit_q) < FIFO_DEPTH) ? int'(limit_q) : FIFO_DEPTH;
			if (depth_used[s] >= lim) begin
				r.status = ST_DROPPED;
			end else begin
				pos = (rd_ptr[s] + depth_used[s]) % FIFO_DEPTH;
				word_ram[s*FIFO_DEPTH + pos] = word;
				depth_used[s]++;
				r.status = ST_QUEUED;
			end
			r.level = LEVEL_W'(depth_used[s]);
		end else begin
			if (depth_used[s] == 0) begin
				r.status = ST_EMPTY;
			end else begin
				top_up(s, now);
				if (bucket[s] < (TOKEN_W'(1) << TOKEN_FRAC_BITS)) begin
					r.status = ST_NO_TOKEN;
				end else if (go) begin
					// spend one token and pop the head
					bucket[s] = bucket[s] - (TOKEN_W'(1) << TOKEN_FRAC_BITS);
					r.word    = word_ram[s*FIFO_DEPTH + rd_ptr[s]];
					rd_ptr[s] = (rd_ptr[s] + 1) % FIFO_DEPTH;
					depth_used[s]--;
					r.status  = ST_DISPATCHED;
				end else begin
					// token refunded, head stays
					r.status = ST_WAITING;
				end
			end
			r.level = LEVEL_W'(depth_used[s]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		int        errs;
		if (!arst_n) begin
			burst_q = BURST_RESET;
			rate_q  = RATE_RESET;
			limit_q = LIMIT_RESET;
			for (int i = 0; i < SOURCES; i++)
				restore_slot(i);
			due_rsp.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;

			// Track register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BURST: burst_q = cfg_data[BURST_W-1:0];
					CFG_RATE:  rate_q  = cfg_data[RATE_W-1:0];
					CFG_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end

			// Compare a response beat with the oldest prediction
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (due_rsp.size() == 0) begin
					$error("response beat with nothing expected: status %0d", rsp_mon.status);
					errs++;
				end else begin
					want = due_rsp[0];
					due_rsp.delete(0);
					if (rsp_mon.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_mon.status);
						errs++;
					end
					if (rsp_mon.dispatched_word !== want.word) begin
						$error("dispatched_word: expected %h, got %h", want.word,
							rsp_mon.dispatched_word);
						errs++;
					end
					if (rsp_mon.queue_level !== want.level) begin
						$error("queue_level: expected %0d, got %0d", want.level,
							rsp_mon.queue_level);
						errs++;
					end
				end
			end

			// Predict the response to a request beat
			if (req_mon.valid && req_mon.ready) begin
				predict_rsp(op_t'(req_mon.operation), req_mon.slot, req_mon.request_word,
					req_mon.now_ms, req_mon.sender_ready, want);
				due_rsp = {due_rsp, want};
			end

			fail_count  <= fail_count + errs;
			outstanding <= due_rsp.size();
		end
	end

endmodule

// ===== sim/per_source_token_bucket_queue_test.sv =====
// Testbench top for the per-source token bucket queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module per_source_token_bucket_queue_test;
	import pstbq_pkg::*;

	localparam int ROUNDS     = 8;
	localparam int ROUND_BEATS = 240;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int              fail_count;
	int              outstanding;
	int              idle_pct;
	int              stall_pct;
	bit              hold_req;
	logic [TIME_W-1:0] clock_ms;

	pstbq_req_if req_ch ();
	pstbq_rsp_if rsp_ch ();

	per_source_token_bucket_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	pstbq_checker rsp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_mon     (req_ch),
		.rsp_mon     (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("FAIL");
		$finish;
	end

	// Response side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left    = 0;
		hold_seen    = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [WORD_BITS-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	// Offer one request beat, wait for it to be taken, then idle at random
	task automatic send_item(input op_t op, input logic [SLOT_W-1:0] sl,
			input logic [WORD_BITS-1:0] w, input logic [TIME_W-1:0] t, input logic go);
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.slot         <= sl;
		req_ch.request_word <= w;
		req_ch.now_ms       <= t;
		req_ch.sender_ready <= go;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	// Drop valid and wait until every response has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input int burst, input int rate, input int limit);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BURST;
		cfg_data  <= CFG_DATA_W'(burst);
		@(posedge clk);
		cfg_index <= CFG_RATE;
		cfg_data  <= CFG_DATA_W'(rate);
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data  <= CFG_DATA_W'(limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed traffic on valid slots, with some noise
	task automatic send_random();
		int                pick;
		int                tsel;
		op_t               op;
		logic [SLOT_W-1:0] sl;
		logic [TIME_W-1:0] t;
		logic              go;
		pick = $urandom_range(99);
		sl   = ($urandom_range(99) < 4) ? '0 : SLOT_W'($urandom_range(SOURCES - 1, 1));
		go   = ($urandom_range(99) < 80);
		t    = rand_time();
		if (pick < 46) begin
			op = OP_ENQUEUE;
		end else if (pick < 92) begin
			op   = OP_SERVICE;
			tsel = $urandom_range(99);
			if (tsel < 4) begin
				t = '0;
			end else if (tsel < 10) begin
				clock_ms = rand_time();
				t        = clock_ms;
			end else if (tsel < 16) begin
				t = clock_ms;
			end else if (tsel < 20) begin
				t = clock_ms - TIME_W'($urandom_range(500));
			end else begin
				clock_ms = clock_ms + TIME_W'($urandom_range(400, 1));
				t        = clock_ms;
			end
		end else if (pick < 97) begin
			op = OP_CLEAR_SLOT;
		end else if (pick < 98) begin
			op = OP_CLEAR_ALL;
		end else begin
			op = op_t'($urandom_range(3));
			sl = SLOT_W'($urandom());
		end
		send_item(op, sl, rand_word(), t, go);
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_BURST;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_ENQUEUE;
		req_ch.slot         = '0;
		req_ch.request_word = '0;
		req_ch.now_ms       = '0;
		req_ch.sender_ready = 1'b0;
		idle_pct            = 0;
		stall_pct           = 0;
		hold_req            = 1'b0;
		clock_ms            = TIME_W'(1000);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad slots, empty service, full FIFO, time corner cases, clears
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(100), 1'b1);
		send_item(OP_ENQUEUE, 3'd0, rand_word(), rand_time(), 1'b1);
		send_item(OP_SERVICE, 3'd0, rand_word(), TIME_W'(100), 1'b1);
		send_item(OP_CLEAR_SLOT, 3'd0, rand_word(), rand_time(), 1'b0);
		send_item(OP_ENQUEUE, 3'd1, '1, '1, 1'b1);
		send_item(OP_ENQUEUE, 3'd1, '0, '0, 1'b0);
		for (int i = 0; i < 7; i++)
			send_item(OP_ENQUEUE, 3'd1, rand_word(), rand_time(), 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), '0, 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(1000), 1'b0);
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(1000), 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(500), 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(500), 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), TIME_W'(501), 1'b1);
		send_item(OP_SERVICE, 3'd1, rand_word(), '1, 1'b1);
		send_item(OP_CLEAR_ALL, 3'd5, rand_word(), rand_time(), 1'b1);
		send_item(OP_ENQUEUE, 3'd7, rand_word(), rand_time(), 1'b0);
		send_item(OP_SERVICE, 3'd7, rand_word(), '1, 1'b1);
		send_item(OP_ENQUEUE, 3'd7, rand_word(), rand_time(), 1'b1);
		send_item(OP_CLEAR_SLOT, 3'd7, rand_word(), rand_time(), 1'b1);
		send_item(OP_SERVICE, 3'd7, rand_word(), TIME_W'(2000), 1'b1);

		// Random rounds, each under its own register setting; the idle and stall pattern repeats every four rounds
		for (int round = 0; round < ROUNDS; round++) begin
			drain();
			case (round)
				0: apply_settings(15, 1000, 8);
				1: apply_settings(1, 0, 1);
				2: apply_settings(4, 4, 8);
				3: apply_settings(0, 1023, 15);
				4: apply_settings(8, 500, 3);
				5: apply_settings(2, 100, 0);
				default: apply_settings($urandom_range(15, 1), $urandom_range(1023),
					$urandom_range(9, 1));
			endcase
			case (round % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			for (int i = 0; i < ROUND_BEATS; i++) begin
				// hold the response side off while requests keep coming
				if (round == 0 && i == 80)
					hold_req = 1'b1;
				send_random();
			end
		end

		drain();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
